@@ sv/imbepn_pkg.sv @@
// Package for the P25 IMBE PN mask generator.
// Holds the generator constants, the pipeline sizing and the jump-ahead functions.
// No dependencies.
package imbepn_pkg;

  localparam int STATE_W = 16;
  localparam int SEED_W = 12;
  localparam int LONG_W = 23;
  localparam int SHORT_W = 15;

  localparam logic [STATE_W-1:0] PN_MUL = 16'd173;
  localparam logic [STATE_W-1:0] PN_ADD = 16'd13849;

  localparam int TOTAL_BITS = 3 * LONG_W + 3 * SHORT_W;
  localparam int STEPS = 6;
  localparam int NUM_STAGES = TOTAL_BITS / STEPS;
  localparam int LATENCY = NUM_STAGES + 1;

  // k-step jump: s_k = mul(k) * s_0 + add(k) mod 2^16
  function automatic logic [STATE_W-1:0] pn_jump_mul(input int k);
    logic [STATE_W-1:0] a;
    a = 16'd1;
    for (int i = 0; i < k; i++) begin
      a = STATE_W'(a * PN_MUL);
    end
    return a;
  endfunction

  function automatic logic [STATE_W-1:0] pn_jump_add(input int k);
    logic [STATE_W-1:0] c;
    c = '0;
    for (int i = 0; i < k; i++) begin
      c = STATE_W'(c * PN_MUL + PN_ADD);
    end
    return c;
  endfunction

endpackage

@@ sv/imbe_pn_mask_generator.sv @@
// P25 IMBE PN mask generator: an accepted start is registered, then passes through the pipeline stages to done.
// Throughput one transaction per cycle; busy is never raised.
// Each of 19 pipeline stages advances the 16-bit generator six steps by jump-ahead.
// Synchronous active-high rst clears all valid bits; data registers are not reset.
// Depends on imbepn_pkg.
module imbe_pn_mask_generator
  import imbepn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [SEED_W-1:0]  seed_vector,
  output logic               done,
  output logic [LONG_W-1:0]  mask_a,
  output logic [LONG_W-1:0]  mask_b,
  output logic [LONG_W-1:0]  mask_c,
  output logic [SHORT_W-1:0] mask_d,
  output logic [SHORT_W-1:0] mask_e,
  output logic [SHORT_W-1:0] mask_f
);

  logic                  v    [0:NUM_STAGES];
  logic [STATE_W-1:0]    st   [0:NUM_STAGES];
  logic [TOTAL_BITS-1:0] bits [0:NUM_STAGES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    st[0]   <= {seed_vector, 4'b0000};
    bits[0] <= '0;
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    logic [STATE_W-1:0] s_k [1:STEPS];
    logic [STEPS-1:0]   nb;

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam logic [STATE_W-1:0] AK = pn_jump_mul(k);
      localparam logic [STATE_W-1:0] CK = pn_jump_add(k);
      assign s_k[k] = STATE_W'(st[g] * AK + CK);
      assign nb[STEPS-k] = s_k[k][STATE_W-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      st[g+1]   <= s_k[STEPS];
      bits[g+1] <= {bits[g][TOTAL_BITS-STEPS-1:0], nb};
    end
  end

  assign done   = v[NUM_STAGES];
  assign mask_a = bits[NUM_STAGES][TOTAL_BITS-1 -: LONG_W];
  assign mask_b = bits[NUM_STAGES][TOTAL_BITS-LONG_W-1 -: LONG_W];
  assign mask_c = bits[NUM_STAGES][TOTAL_BITS-2*LONG_W-1 -: LONG_W];
  assign mask_d = bits[NUM_STAGES][3*SHORT_W-1 -: SHORT_W];
  assign mask_e = bits[NUM_STAGES][2*SHORT_W-1 -: SHORT_W];
  assign mask_f = bits[NUM_STAGES][SHORT_W-1:0];

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_fwd_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transaction lost in pipeline");

  a_bwd_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without matching start");

endmodule
